[rtl/tlbs_pkg.sv]
// Shared types and constants for the table search block.
package tlbs_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int BND_W   = CNT_W + 1;  // signed binary-search bound
	localparam int VALUE_W = 32;
	localparam int OP_W    = 2;
	localparam int POS_W   = 7;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_LINEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_SORTED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic signed [VALUE_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} out_t;

	// result of the shared comparator: a == b, a < b (signed)
	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_t;

endpackage

[rtl/tlbs_cmp.sv]
// Shared signed comparator used by every search and sort step.
module tlbs_cmp (
	input  logic signed [tlbs_pkg::VALUE_W-1:0] a,
	input  logic signed [tlbs_pkg::VALUE_W-1:0] b,
	output tlbs_pkg::cmp_t                      res
);

	always_comb begin
		res.eq = (a == b);
		res.lt = (a < b);
	end

endmodule

[rtl/table_linear_and_binary_search_top.sv]
// Top level: entry table, search/sort sequencer and result register.
//
// Usage
//   Command channel: drive item (operation, value) with start; the item is
//   taken at a rising edge where start is high and busy is low.
//   Clear and append finish in the accepting cycle: busy stays low and no
//   result is produced. Append to a full table is dropped.
//   Linear search and sorted search raise busy from the next cycle and
//   produce exactly one result: done is high for one cycle with result
//   (found, position). position is 1-based, 0 on a miss.
//   Busy stretches (n = entries, up to 64; done rises in the cycle busy falls):
//     linear search : examines entries in order until a match or the end.
//     sorted search : sorts the n entries, then probes them by binary
//                     search until a match or an empty bound range.
//   Every step goes through the single-port table read (registered data)
//   and one shared comparator; each compare waits for the registered read.
//   The sort order is kept in the table and seen by later searches.
//   Reset (arst_n low) empties the table and returns the sequencer to idle;
//   table contents are not cleared, only the count.
//   The receiver cannot stall: a result must be taken in its done cycle.
module table_linear_and_binary_search_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tlbs_pkg::in_t  item,
	output logic           busy,
	output logic           done,
	output tlbs_pkg::out_t result
);

	localparam int IDX_W = tlbs_pkg::IDX_W;
	localparam int CNT_W = tlbs_pkg::CNT_W;
	localparam int BND_W = tlbs_pkg::BND_W;
	localparam int VW    = tlbs_pkg::VALUE_W;
	localparam int POS_W = tlbs_pkg::POS_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_LIN_RD  = 4'd1;
	localparam logic [3:0] ST_LIN_CMP = 4'd2;
	localparam logic [3:0] ST_SRT_LD  = 4'd3;
	localparam logic [3:0] ST_SRT_LDW = 4'd4;
	localparam logic [3:0] ST_SRT_RD  = 4'd5;
	localparam logic [3:0] ST_SRT_CMP = 4'd6;
	localparam logic [3:0] ST_BIN_RD  = 4'd7;
	localparam logic [3:0] ST_BIN_CMP = 4'd8;

	logic [3:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        i_q;
	logic [CNT_W-1:0]        j_q;
	logic signed [VW-1:0]    key_q;
	logic signed [VW-1:0]    cur_q;    // entry being inserted: starts as entry i, then carries displaced entries
	logic signed [BND_W-1:0] lo_q;
	logic signed [BND_W-1:0] hi_q;
	logic [IDX_W-1:0]        mid_q;
	logic                    done_q;
	tlbs_pkg::out_t          result_q;

	// table memory, one write and one registered read per cycle
	logic signed [VW-1:0]    mem [tlbs_pkg::DEPTH];
	logic signed [VW-1:0]    rd_data_q;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic signed [VW-1:0]    wr_data;

	logic                    accept;
	logic [BND_W:0]          bnd_sum;
	logic [IDX_W-1:0]        mid;
	logic signed [VW-1:0]    cmp_a;
	logic signed [VW-1:0]    cmp_b;
	tlbs_pkg::cmp_t          cmp;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign result  = result_q;

	// lo+hi is only used while lo <= hi, so it is non-negative there
	assign bnd_sum = {lo_q[BND_W-1], lo_q} + {hi_q[BND_W-1], hi_q};
	assign mid     = bnd_sum[IDX_W:1];

	// sort compares held entry against entry j; searches compare entry with key
	assign cmp_a = (state_q == ST_SRT_CMP) ? cur_q : rd_data_q;
	assign cmp_b = (state_q == ST_SRT_CMP) ? rd_data_q : key_q;

	tlbs_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	// memory port steering
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = item.value;
		unique case (state_q)
			ST_IDLE: begin
				wr_en = accept && (item.operation == tlbs_pkg::OP_APPEND)
					&& (count_q < CNT_W'(tlbs_pkg::DEPTH));
			end
			ST_LIN_RD: begin
				rd_en = (i_q != count_q);
			end
			ST_SRT_LD: begin
				rd_en = (i_q != count_q);
			end
			ST_SRT_RD: begin
				if (j_q == i_q) begin
					wr_en   = 1'b1;
					wr_addr = i_q[IDX_W-1:0];
					wr_data = cur_q;
				end else begin
					rd_en   = 1'b1;
					rd_addr = j_q[IDX_W-1:0];
				end
			end
			ST_SRT_CMP: begin
				wr_en   = cmp.lt;
				wr_addr = j_q[IDX_W-1:0];
				wr_data = cur_q;
			end
			ST_BIN_RD: begin
				rd_en   = (lo_q <= hi_q);
				rd_addr = mid;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q <= item.value;
						i_q   <= '0;
						case (item.operation)
							tlbs_pkg::OP_CLEAR: count_q <= '0;
							tlbs_pkg::OP_APPEND: begin
								if (count_q < CNT_W'(tlbs_pkg::DEPTH)) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							tlbs_pkg::OP_LINEAR: state_q <= ST_LIN_RD;
							default: state_q <= ST_SRT_LD;
						endcase
					end
				end
				ST_LIN_RD: begin
					if (i_q == count_q) begin
						done_q            <= 1'b1;
						result_q.found    <= 1'b0;
						result_q.position <= '0;
						state_q           <= ST_IDLE;
					end else begin
						state_q <= ST_LIN_CMP;
					end
				end
				ST_LIN_CMP: begin
					if (cmp.eq) begin
						done_q            <= 1'b1;
						result_q.found    <= 1'b1;
						result_q.position <= POS_W'(i_q + CNT_W'(1));
						state_q           <= ST_IDLE;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_LIN_RD;
					end
				end
				ST_SRT_LD: begin
					if (i_q == count_q) begin
						lo_q    <= '0;
						hi_q    <= $signed(BND_W'(count_q) - BND_W'(1));
						state_q <= ST_BIN_RD;
					end else begin
						j_q     <= '0;
						state_q <= ST_SRT_LDW;
					end
				end
				ST_SRT_LDW: begin
					cur_q   <= rd_data_q;
					state_q <= ST_SRT_RD;
				end
				ST_SRT_RD: begin
					if (j_q == i_q) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_SRT_LD;
					end else begin
						state_q <= ST_SRT_CMP;
					end
				end
				ST_SRT_CMP: begin
					// held entry smaller: it goes to j, entry j is carried on
					if (cmp.lt) begin
						cur_q <= rd_data_q;
					end
					j_q     <= j_q + CNT_W'(1);
					state_q <= ST_SRT_RD;
				end
				ST_BIN_RD: begin
					if (lo_q > hi_q) begin
						done_q            <= 1'b1;
						result_q.found    <= 1'b0;
						result_q.position <= '0;
						state_q           <= ST_IDLE;
					end else begin
						mid_q   <= mid;
						state_q <= ST_BIN_CMP;
					end
				end
				ST_BIN_CMP: begin
					if (cmp.eq) begin
						done_q            <= 1'b1;
						result_q.found    <= 1'b1;
						result_q.position <= POS_W'(CNT_W'(mid_q) + CNT_W'(1));
						state_q           <= ST_IDLE;
					end else begin
						if (cmp.lt) begin
							lo_q <= $signed(BND_W'(mid_q) + BND_W'(1));
						end else begin
							hi_q <= $signed(BND_W'(mid_q) - BND_W'(1));
						end
						state_q <= ST_BIN_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a result only ever closes a busy stretch
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding search");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(tlbs_pkg::DEPTH))
		else $error("entry count beyond table depth");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.position == '0)
		else $error("miss with nonzero position");

	a_search_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.operation == tlbs_pkg::OP_LINEAR ||
			item.operation == tlbs_pkg::OP_SORTED) |=> busy)
		else $error("search accepted but sequencer idle");

	a_sort_inner_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRT_CMP |-> (j_q < i_q) && (i_q < count_q))
		else $error("sort index out of range");

endmodule
